@@ rtl/cnm_pkg.sv @@
// cnm_pkg: types, widths and register codes of the cosine nearest match unit
// used by the rtl files of the block other than cnm_ram and cnm_fifo, depends on nothing

package cnm_pkg;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int DEF_MAX_LENGTH  = 256;
  localparam int ELEMENT_BITS    = 16;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THRESHOLD = 2'd2;

  localparam int VLEN_W = 9;
  localparam int ECNT_W = 7;
  localparam int THR_W  = 16;

  localparam logic [VLEN_W-1:0] VLEN_RST = 9'd256;
  localparam logic [ECNT_W-1:0] ECNT_RST = 7'd64;
  localparam logic [THR_W-1:0]  THR_RST  = 16'd26214;

  // sized for the largest store the parameters allow
  localparam int LEN_FW  = 13;
  localparam int CNT_FW  = 11;
  localparam int PRD_W   = 2 * ELEMENT_BITS;
  localparam int DOT_W   = 44;
  localparam int MAG_W   = DOT_W - 1;
  localparam int PROD_W  = 120;
  localparam int SC_W    = 16;
  localparam int SQ_W    = 2 * SC_W;
  localparam int BIT_W   = 4;
  localparam int R_SHIFT = 30;

  typedef struct packed {
    logic                           command;
    logic [5:0]                     entry_index;
    logic [7:0]                     element_index;
    logic signed [ELEMENT_BITS-1:0] element_value;
    logic [15:0]                    object_id;
    logic                           last_element;
  } in_item_t;

  typedef struct packed {
    logic        match_found;
    logic [15:0] matched_id;
    logic [15:0] best_similarity;
  } out_item_t;

  typedef struct packed {
    logic [LEN_FW-1:0] len;
    logic [CNT_FW-1:0] cnt;
    logic [THR_W-1:0]  thr;
  } job_t;

endpackage

@@ rtl/cnm_ram.sv @@
// cnm_ram: generic single write port ram with one registered read port
// no dependencies

module cnm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/cnm_fifo.sv @@
// cnm_fifo: small register queue with full and empty flags
// no dependencies

module cnm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = cnt_r == CW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

@@ rtl/cnm_mul.sv @@
// cnm_mul: shift and add multiplier, one multiplier bit per cycle
// depends on cnm_pkg

module cnm_mul import cnm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] a,
  input  logic [MAG_W-1:0]  b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  localparam int CW = $clog2(MAG_W);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [PROD_W-1:0] a_r, a_nxt, acc_r, acc_nxt;
  logic [MAG_W-1:0]  b_r, b_nxt;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      a_nxt   = a;
      b_nxt   = b;
      acc_nxt = '0;
    end else if (run_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt   = a_r << 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(MAG_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

@@ rtl/cnm_front.sv @@
// cnm_front: accepts items and register writes, clears and fills the stores,
// hands search jobs to the back end; depends on cnm_pkg

module cnm_front import cnm_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
  localparam int FEAT_DEPTH = MAX_ENTRIES * MAX_LENGTH,
  localparam int FEAT_AW    = FEAT_DEPTH > 1 ? $clog2(FEAT_DEPTH) : 1,
  localparam int ENT_AW     = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1,
  localparam int LEN_AW     = MAX_LENGTH > 1 ? $clog2(MAX_LENGTH) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  in_item_t                in_item,
  output logic                    in_full,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data,
  output logic                    feat_we,
  output logic [FEAT_AW-1:0]      feat_waddr,
  output logic [ELEMENT_BITS-1:0] feat_wdata,
  output logic                    id_we,
  output logic [ENT_AW-1:0]       id_waddr,
  output logic [15:0]             id_wdata,
  output logic                    qry_we,
  output logic [LEN_AW-1:0]       qry_waddr,
  output logic [ELEMENT_BITS-1:0] qry_wdata,
  output logic                    job_push,
  output job_t                    job,
  input  logic                    search_done
);

  logic                clearing_r, clearing_nxt;
  logic [FEAT_AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic                busy_r, busy_nxt;
  logic [VLEN_W-1:0]   vlen_r, vlen_nxt;
  logic [ECNT_W-1:0]   ecnt_r, ecnt_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;
  logic                accept, load_ok;
  logic [31:0]         ent_ext, pos_ext, feat_addr_full;

  assign in_full   = clearing_r || busy_r;
  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  assign ent_ext        = 32'(in_item.entry_index);
  assign pos_ext        = 32'(in_item.element_index);
  assign load_ok        = ent_ext < 32'(MAX_ENTRIES) && pos_ext < 32'(MAX_LENGTH);
  assign feat_addr_full = ent_ext * 32'(MAX_LENGTH) + pos_ext;

  always_comb begin
    feat_we    = 1'b0;
    feat_waddr = feat_addr_full[FEAT_AW-1:0];
    feat_wdata = in_item.element_value;
    id_we      = 1'b0;
    id_waddr   = ent_ext[ENT_AW-1:0];
    id_wdata   = in_item.object_id;
    qry_we     = 1'b0;
    qry_waddr  = pos_ext[LEN_AW-1:0];
    qry_wdata  = in_item.element_value;
    job_push   = 1'b0;
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    busy_nxt     = busy_r;
    if (search_done) begin
      busy_nxt = 1'b0;
    end
    if (clearing_r) begin
      feat_we    = 1'b1;
      feat_waddr = clr_addr_r;
      feat_wdata = '0;
      id_we      = 32'(clr_addr_r) < 32'(MAX_ENTRIES);
      id_waddr   = clr_addr_r[ENT_AW-1:0];
      id_wdata   = '0;
      clr_addr_nxt = clr_addr_r + FEAT_AW'(1);
      if (clr_addr_r == FEAT_AW'(FEAT_DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!in_item.command) begin
        feat_we = load_ok;
        id_we   = load_ok;
      end else begin
        qry_we = pos_ext < 32'(MAX_LENGTH);
        if (in_item.last_element) begin
          job_push = 1'b1;
          busy_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    job.len = (LEN_FW'(vlen_r) < LEN_FW'(MAX_LENGTH)) ? LEN_FW'(vlen_r) : LEN_FW'(MAX_LENGTH);
    job.cnt = (CNT_FW'(ecnt_r) < CNT_FW'(MAX_ENTRIES)) ? CNT_FW'(ecnt_r)
                                                        : CNT_FW'(MAX_ENTRIES);
    job.thr = thr_r;
  end

  always_comb begin
    vlen_nxt = vlen_r;
    ecnt_nxt = ecnt_r;
    thr_nxt  = thr_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_VECTOR_LENGTH:   vlen_nxt = cfg_data[VLEN_W-1:0];
        CFG_ENTRIES_IN_USE:  ecnt_nxt = cfg_data[ECNT_W-1:0];
        CFG_MATCH_THRESHOLD: thr_nxt  = cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      busy_r     <= 1'b0;
      vlen_r     <= VLEN_RST;
      ecnt_r     <= ECNT_RST;
      thr_r      <= THR_RST;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
      busy_r     <= busy_nxt;
      vlen_r     <= vlen_nxt;
      ecnt_r     <= ecnt_nxt;
      thr_r      <= thr_nxt;
    end
  end

endmodule

@@ rtl/cnm_back.sv @@
// cnm_back: runs one search, dot products and norms per entry, exact score by
// bit-serial root search; depends on cnm_pkg and cnm_mul

module cnm_back import cnm_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
  localparam int FEAT_DEPTH = MAX_ENTRIES * MAX_LENGTH,
  localparam int FEAT_AW    = FEAT_DEPTH > 1 ? $clog2(FEAT_DEPTH) : 1,
  localparam int ENT_AW     = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1,
  localparam int LEN_AW     = MAX_LENGTH > 1 ? $clog2(MAX_LENGTH) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_empty,
  input  job_t                    job,
  output logic                    job_pop,
  output logic [FEAT_AW-1:0]      feat_raddr,
  input  logic [ELEMENT_BITS-1:0] feat_rdata,
  output logic [LEN_AW-1:0]       qry_raddr,
  input  logic [ELEMENT_BITS-1:0] qry_rdata,
  output logic [ENT_AW-1:0]       id_raddr,
  input  logic [15:0]             id_rdata,
  input  logic                    res_full,
  output logic                    res_push,
  output out_item_t               res,
  output logic                    search_done
);

  localparam int LEN_CW = $clog2(MAX_LENGTH + 1);
  localparam int CNT_CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ACC    = 9'b000000010,
    S_DRAIN  = 9'b000000100,
    S_MUL_R  = 9'b000001000,
    S_MUL_P  = 9'b000010000,
    S_TRIAL  = 9'b000100000,
    S_PICK   = 9'b001000000,
    S_IDREAD = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [LEN_CW-1:0]        len_r, len_nxt, k_r, k_nxt;
  logic [CNT_CW-1:0]        cnt_r, cnt_nxt, e_r, e_nxt;
  logic [THR_W-1:0]         thr_r, thr_nxt;
  logic [FEAT_AW-1:0]       base_r, base_nxt;
  logic                     v1_r, v1_nxt, v2_r, v2_nxt;
  logic signed [PRD_W-1:0]  qr_r, rr_r, qq_r;
  logic signed [DOT_W-1:0]  dot_r, dot_nxt;
  logic [MAG_W-1:0]         nb_r, nb_nxt, na_r, na_nxt;
  logic [PROD_W-1:0]        rbig_r, rbig_nxt, pbig_r, pbig_nxt;
  logic [SC_W-1:0]          s_r, s_nxt, t_r, t_nxt, best_r, best_nxt;
  logic [SQ_W-1:0]          sq_r, sq_nxt, tsq_r, tsq_nxt;
  logic [BIT_W-1:0]         bit_r, bit_nxt;
  logic [ENT_AW-1:0]        beste_r, beste_nxt;
  logic                     mstart_r, mstart_nxt;
  logic [PROD_W-1:0]        ma_r, ma_nxt;
  logic [MAG_W-1:0]         mb_r, mb_nxt;
  logic                     mul_done;
  logic [PROD_W-1:0]        mul_prod;
  logic [SC_W-1:0]          s_b, tr_t;
  logic [SQ_W-1:0]          sq_b;
  logic [BIT_W-1:0]         bit_b;
  logic [SQ_W:0]            tr_sq;
  logic                     le, match;

  cnm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mstart_r),
    .a     (ma_r),
    .b     (mb_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign feat_raddr = base_r + FEAT_AW'(k_r);
  assign qry_raddr  = k_r[LEN_AW-1:0];
  assign id_raddr   = beste_r;
  assign le         = mul_prod <= rbig_r;

  always_comb begin
    if (state_r == S_TRIAL) begin
      s_b   = le ? t_r : s_r;
      sq_b  = le ? tsq_r : sq_r;
      bit_b = bit_r - BIT_W'(1);
    end else begin
      s_b   = '0;
      sq_b  = '0;
      bit_b = BIT_W'(SC_W - 1);
    end
    tr_t  = s_b | (SC_W'(1) << bit_b);
    tr_sq = (SQ_W + 1)'(sq_b) + ((SQ_W + 1)'(s_b) << (5'(bit_b) + 5'd1))
          + ((SQ_W + 1)'(1) << {bit_b, 1'b0});
  end

  assign match = best_r != '0 && best_r >= thr_r;

  always_comb begin
    res.match_found     = match;
    res.matched_id      = match ? id_rdata : '0;
    res.best_similarity = best_r;
  end

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    thr_nxt    = thr_r;
    k_nxt      = k_r;
    e_nxt      = e_r;
    base_nxt   = base_r;
    v1_nxt     = 1'b0;
    v2_nxt     = v1_r;
    dot_nxt    = dot_r;
    nb_nxt     = nb_r;
    na_nxt     = na_r;
    rbig_nxt   = rbig_r;
    pbig_nxt   = pbig_r;
    s_nxt      = s_r;
    sq_nxt     = sq_r;
    t_nxt      = t_r;
    tsq_nxt    = tsq_r;
    bit_nxt    = bit_r;
    best_nxt   = best_r;
    beste_nxt  = beste_r;
    mstart_nxt = 1'b0;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    job_pop    = 1'b0;
    res_push   = 1'b0;
    search_done = 1'b0;

    if (v2_r) begin
      dot_nxt = dot_r + DOT_W'(qr_r);
      nb_nxt  = nb_r + MAG_W'(unsigned'(rr_r));
      if (e_r == '0) begin
        na_nxt = na_r + MAG_W'(unsigned'(qq_r));
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          len_nxt   = job.len[LEN_CW-1:0];
          cnt_nxt   = job.cnt[CNT_CW-1:0];
          thr_nxt   = job.thr;
          k_nxt     = '0;
          e_nxt     = '0;
          base_nxt  = '0;
          best_nxt  = '0;
          beste_nxt = '0;
          dot_nxt   = '0;
          nb_nxt    = '0;
          na_nxt    = '0;
          state_nxt = (job.len == '0 || job.cnt == '0) ? S_IDREAD : S_ACC;
        end
      end
      S_ACC: begin
        v1_nxt = 1'b1;
        k_nxt  = k_r + LEN_CW'(1);
        if (k_r == len_r - LEN_CW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) begin
          s_nxt  = '0;
          sq_nxt = '0;
          if (!dot_r[DOT_W-1] && dot_r != '0 && na_r != '0 && nb_r != '0) begin
            ma_nxt     = PROD_W'(dot_r[MAG_W-1:0]);
            mb_nxt     = dot_r[MAG_W-1:0];
            mstart_nxt = 1'b1;
            state_nxt  = S_MUL_R;
          end else begin
            state_nxt = S_PICK;
          end
        end
      end
      S_MUL_R: begin
        if (mul_done) begin
          rbig_nxt   = mul_prod << R_SHIFT;
          ma_nxt     = PROD_W'(na_r);
          mb_nxt     = nb_r;
          mstart_nxt = 1'b1;
          state_nxt  = S_MUL_P;
        end
      end
      S_MUL_P: begin
        if (mul_done) begin
          pbig_nxt   = mul_prod;
          bit_nxt    = bit_b;
          t_nxt      = tr_t;
          tsq_nxt    = tr_sq[SQ_W-1:0];
          ma_nxt     = mul_prod;
          mb_nxt     = MAG_W'(tr_sq[SQ_W-1:0]);
          mstart_nxt = 1'b1;
          state_nxt  = S_TRIAL;
        end
      end
      S_TRIAL: begin
        if (mul_done) begin
          s_nxt  = s_b;
          sq_nxt = sq_b;
          if (bit_r == '0) begin
            state_nxt = S_PICK;
          end else begin
            bit_nxt    = bit_b;
            t_nxt      = tr_t;
            tsq_nxt    = tr_sq[SQ_W-1:0];
            ma_nxt     = pbig_r;
            mb_nxt     = MAG_W'(tr_sq[SQ_W-1:0]);
            mstart_nxt = 1'b1;
          end
        end
      end
      S_PICK: begin
        if (s_r > best_r) begin
          best_nxt  = s_r;
          beste_nxt = e_r[ENT_AW-1:0];
        end
        if (e_r == cnt_r - CNT_CW'(1)) begin
          state_nxt = S_IDREAD;
        end else begin
          e_nxt     = e_r + CNT_CW'(1);
          base_nxt  = base_r + FEAT_AW'(MAX_LENGTH);
          k_nxt     = '0;
          dot_nxt   = '0;
          nb_nxt    = '0;
          state_nxt = S_ACC;
        end
      end
      S_IDREAD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!res_full) begin
          res_push    = 1'b1;
          search_done = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      mstart_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      v1_r     <= v1_nxt;
      v2_r     <= v2_nxt;
      mstart_r <= mstart_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    cnt_r   <= cnt_nxt;
    thr_r   <= thr_nxt;
    k_r     <= k_nxt;
    e_r     <= e_nxt;
    base_r  <= base_nxt;
    qr_r    <= $signed(qry_rdata) * $signed(feat_rdata);
    rr_r    <= $signed(feat_rdata) * $signed(feat_rdata);
    qq_r    <= $signed(qry_rdata) * $signed(qry_rdata);
    dot_r   <= dot_nxt;
    nb_r    <= nb_nxt;
    na_r    <= na_nxt;
    rbig_r  <= rbig_nxt;
    pbig_r  <= pbig_nxt;
    s_r     <= s_nxt;
    sq_r    <= sq_nxt;
    t_r     <= t_nxt;
    tsq_r   <= tsq_nxt;
    bit_r   <= bit_nxt;
    best_r  <= best_nxt;
    beste_r <= beste_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
  end

endmodule

@@ rtl/cosine_nearest_match_unit.sv @@
// Cosine nearest match unit. Load items and query elements other than the
// last are taken one per clock while in_full is low. After reset the feature
// store is cleared address by address with in_full high. A last query element
// starts a search that holds in_full high until its result is queued: each
// entry in use reads as many elements as the vector length through the single
// read port of the feature store, then the bit-serial multiplier settles the
// exact 16-bit score (two products plus sixteen trial products of 43 steps
// each). Results wait in a two-deep output queue.
// Depends on cnm_pkg, cnm_front, cnm_back, cnm_mul, cnm_fifo and cnm_ram.

module cosine_nearest_match_unit import cnm_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int MAX_LENGTH  = DEF_MAX_LENGTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  in_item_t             in_item,
  output logic                 in_full,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int FEAT_DEPTH = MAX_ENTRIES * MAX_LENGTH;
  localparam int FEAT_AW    = FEAT_DEPTH > 1 ? $clog2(FEAT_DEPTH) : 1;
  localparam int ENT_AW     = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
  localparam int LEN_AW     = MAX_LENGTH > 1 ? $clog2(MAX_LENGTH) : 1;

  logic                    feat_we, id_we, qry_we;
  logic [FEAT_AW-1:0]      feat_waddr, feat_raddr;
  logic [ELEMENT_BITS-1:0] feat_wdata, feat_rdata, qry_wdata, qry_rdata;
  logic [ENT_AW-1:0]       id_waddr, id_raddr;
  logic [15:0]             id_wdata, id_rdata;
  logic [LEN_AW-1:0]       qry_waddr, qry_raddr;
  logic                    job_push, job_full, job_pop, job_empty, search_done;
  job_t                    job_in, job_out;
  logic                    res_push, res_full;
  out_item_t               res;

  cnm_front #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_item     (in_item),
    .in_full     (in_full),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .feat_we     (feat_we),
    .feat_waddr  (feat_waddr),
    .feat_wdata  (feat_wdata),
    .id_we       (id_we),
    .id_waddr    (id_waddr),
    .id_wdata    (id_wdata),
    .qry_we      (qry_we),
    .qry_waddr   (qry_waddr),
    .qry_wdata   (qry_wdata),
    .job_push    (job_push),
    .job         (job_in),
    .search_done (search_done)
  );

  cnm_fifo #(.WIDTH($bits(job_t)), .DEPTH(2)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  cnm_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(FEAT_DEPTH)) u_feat_ram (
    .clk   (clk),
    .we    (feat_we),
    .waddr (feat_waddr),
    .wdata (feat_wdata),
    .raddr (feat_raddr),
    .rdata (feat_rdata)
  );

  cnm_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (id_wdata),
    .raddr (id_raddr),
    .rdata (id_rdata)
  );

  cnm_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(MAX_LENGTH)) u_qry_ram (
    .clk   (clk),
    .we    (qry_we),
    .waddr (qry_waddr),
    .wdata (qry_wdata),
    .raddr (qry_raddr),
    .rdata (qry_rdata)
  );

  cnm_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_empty   (job_empty || job_full == 1'b1 && 1'b0),
    .job         (job_out),
    .job_pop     (job_pop),
    .feat_raddr  (feat_raddr),
    .feat_rdata  (feat_rdata),
    .qry_raddr   (qry_raddr),
    .qry_rdata   (qry_rdata),
    .id_raddr    (id_raddr),
    .id_rdata    (id_rdata),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res),
    .search_done (search_done)
  );

  cnm_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

@@ rtl/cnm_checker.sv @@
// cnm_checker: port-level checks of the cosine nearest match unit, bound to
// the top level; depends on cnm_pkg

module cnm_checker import cnm_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_push,
  input in_item_t             in_item,
  input logic                 in_full,
  input logic                 out_empty,
  input logic                 out_pop,
  input out_item_t            out_item,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_DAT_W-1:0] cfg_data
);

  logic in_beat;

  assign in_beat = in_push && !in_full;

  a_reset_blocks_input: assert property (@(posedge clk)
    !rst_n |=> in_full && out_empty)
    else $error("input open or result present right after reset");

  a_search_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_item.command && in_item.last_element |=> in_full)
    else $error("input open while a search runs");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && out_empty && !(in_item.command && in_item.last_element) |=> out_empty)
    else $error("result without a search");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("waiting result changed");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_index == CFG_MATCH_THRESHOLD |-> cfg_ready || cfg_data == '0)
    else $error("register write refused");

endmodule

bind cosine_nearest_match_unit cnm_checker u_cnm_checker (.*);
